// ===== rtl/u8u16_pkg.sv =====
package u8u16_pkg;

	localparam logic [15:0] REPL_UNIT   = 16'hFFFD;
	localparam logic [20:0] SUPP_BASE   = 21'h10000;
	localparam logic [15:0] HI_SURR     = 16'hD800;
	localparam logic [15:0] LO_SURR     = 16'hDC00;
	localparam int          UNITS_MAX   = 3;

	// Byte class: ascii, a lead with 1..3 following bytes, or invalid
	typedef struct packed {
		logic       bad;
		logic [1:0] follow;
	} u8u16_class_t;

	// One queue entry: all units caused by one accepted byte
	typedef struct packed {
		logic [UNITS_MAX-1:0][15:0] units;
		logic [1:0]                 cnt;
		logic                       last;
	} u8u16_entry_t;

	function automatic u8u16_class_t fn_classify(input logic [7:0] c);
		u8u16_class_t r;
		r.bad    = 1'b0;
		r.follow = 2'd0;
		priority if (c[7] == 1'b0) begin
			r.follow = 2'd0;
		end else if ((c & 8'hE0) == 8'hC0) begin
			r.follow = 2'd1;
		end else if ((c & 8'hF0) == 8'hE0) begin
			r.follow = 2'd2;
		end else if ((c & 8'hF8) == 8'hF0) begin
			r.follow = 2'd3;
		end else begin
			r.bad = 1'b1;
		end
		return r;
	endfunction

	// Ascii passes through, anything else in a cut-short tail is a replacement
	function automatic logic [15:0] fn_single(input logic [7:0] c);
		return c[7] ? REPL_UNIT : {8'h00, c};
	endfunction

endpackage

// ===== rtl/utf8_to_utf16_transcoder_unit.sv =====
// UTF-8 to UTF-16 transcoder.
// Slave channel: one UTF-8 byte per request on s_tdata, s_tlast marking the
// final byte of a string. Master channel: one UTF-16 code unit per request on
// m_tdata, m_tuser flagging the last unit caused by an input byte, m_tlast the
// final unit of the string.
// A byte accepted by the front is written into the queue; its first unit is then
// loaded into the output register that drives m_tdata. Bytes that only start or
// extend a multi-byte form give no unit.
// Throughput: one byte per cycle while each byte yields at most one unit and the
// receiver takes every unit; the output register emits one unit per cycle while
// m_tready is high, so a surrogate pair gives two units and a string cut short
// mid-form up to three. A queue of QUEUE_DEPTH entries between the decoder and the
// output absorbs such bursts; s_tready drops only when the queue is full.
// Reset clears the decoder state, empties the queue and drops m_tvalid.
// When the receiver stalls, the presented unit holds; decoding carries on
// until the queue fills.
module utf8_to_utf16_transcoder_unit #(
	parameter int QUEUE_DEPTH = 4   // 2 or more
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // string_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] code_unit
	output logic        m_tlast,   // string_end
	output logic        m_tuser    // [0] run_end
);

	u8u16_pkg::u8u16_entry_t wr_entry;
	u8u16_pkg::u8u16_entry_t head;
	logic                    accept;
	logic                    push;
	logic                    pop;
	logic                    not_empty;
	logic                    full;

	// Accept a request whenever the queue has room
	assign s_tready = !full;
	assign accept   = s_tvalid && s_tready;

	// Front: classify the byte, track the form being gathered, build the units
	u8u16_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.in_byte     (s_tdata),
		.string_last (s_tlast),
		.push        (push),
		.entry       (wr_entry)
	);

	// Hold decoded unit groups until the output side takes them
	u8u16_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.wr_entry  (wr_entry),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	// Back: serialise each group, one unit per request
	u8u16_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (not_empty),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

endmodule

// ===== rtl/u8u16_front.sv =====
module u8u16_front (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic [7:0]              in_byte,
	input  logic                    string_last,
	output logic                    push,
	output u8u16_pkg::u8u16_entry_t entry
);

	logic [7:0]      lead_q;
	logic [1:0][7:0] tail_q;
	logic [1:0]      count_q;
	logic [1:0]      needed_q;

	u8u16_pkg::u8u16_class_t cls_in;
	u8u16_pkg::u8u16_class_t cls_t0;
	logic            idle;
	logic            complete;
	logic [20:0]     cp;
	logic [20:0]     cp_off;
	logic [1:0]      count_new;
	logic [1:0][7:0] tail_new;

	assign cls_in   = u8u16_pkg::fn_classify(in_byte);
	assign idle     = (needed_q == 2'd0);
	assign complete = !idle && (({1'b0, count_q} + 3'd1) >= {1'b0, needed_q});

	always_comb begin
		tail_new             = tail_q;
		tail_new[count_q[0]] = in_byte;
		count_new            = count_q + 2'd1;
	end

	assign cls_t0 = u8u16_pkg::fn_classify(tail_new[0]);

	// Gather the code point of a completed form
	always_comb begin
		unique case (needed_q)
			2'd1:    cp = {10'd0, lead_q[4:0], in_byte[5:0]};
			2'd2:    cp = {5'd0, lead_q[3:0], tail_q[0][5:0], in_byte[5:0]};
			default: cp = {lead_q[2:0], tail_q[0][5:0], tail_q[1][5:0], in_byte[5:0]};
		endcase
	end

	assign cp_off = cp - u8u16_pkg::SUPP_BASE;

	always_comb begin
		entry.units = '0;
		entry.cnt   = 2'd0;
		entry.last  = string_last;
		if (idle) begin
			if (!cls_in.bad && cls_in.follow == 2'd0) begin
				entry.units[0] = {8'h00, in_byte};
				entry.cnt      = 2'd1;
			end else if (cls_in.bad || string_last) begin
				entry.units[0] = u8u16_pkg::REPL_UNIT;
				entry.cnt      = 2'd1;
			end
		end else if (complete) begin
			if (cp[20:16] != 5'd0) begin
				entry.units[0] = u8u16_pkg::HI_SURR + {5'd0, cp_off[20:10]};
				entry.units[1] = u8u16_pkg::LO_SURR + {6'd0, cp_off[9:0]};
				entry.cnt      = 2'd2;
			end else begin
				entry.units[0] = cp[15:0];
				entry.cnt      = 2'd1;
			end
		end else if (string_last) begin
			// Form cut short: replacement for the lead, then decode the tail
			entry.units[0] = u8u16_pkg::REPL_UNIT;
			if (count_new < 2'd2) begin
				entry.units[1] = u8u16_pkg::fn_single(tail_new[0]);
				entry.cnt      = 2'd2;
			end else if (!cls_t0.bad && cls_t0.follow == 2'd1) begin
				entry.units[1] = {5'd0, tail_new[0][4:0], tail_new[1][5:0]};
				entry.cnt      = 2'd2;
			end else begin
				entry.units[1] = u8u16_pkg::fn_single(tail_new[0]);
				entry.units[2] = u8u16_pkg::fn_single(tail_new[1]);
				entry.cnt      = 2'd3;
			end
		end
	end

	assign push = accept && (entry.cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			needed_q <= '0;
		end else if (accept) begin
			if (idle) begin
				if (!cls_in.bad && cls_in.follow != 2'd0 && !string_last) begin
					lead_q   <= in_byte;
					needed_q <= cls_in.follow;
					count_q  <= 2'd0;
				end
			end else if (complete) begin
				needed_q <= 2'd0;
				count_q  <= 2'd0;
			end else begin
				tail_q <= tail_new;
				if (string_last) begin
					needed_q <= 2'd0;
					count_q  <= 2'd0;
				end else begin
					count_q <= count_new;
				end
			end
		end
	end

endmodule

// ===== rtl/u8u16_queue.sv =====
module u8u16_queue #(
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  u8u16_pkg::u8u16_entry_t wr_entry,
	input  logic                    pop,
	output u8u16_pkg::u8u16_entry_t head,
	output logic                    not_empty,
	output logic                    full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	u8u16_pkg::u8u16_entry_t mem_q [DEPTH];
	logic [PW-1:0]           wr_ptr_q;
	logic [PW-1:0]           rd_ptr_q;
	logic [CW-1:0]           cnt_q;

	assign head      = mem_q[rd_ptr_q];
	assign not_empty = (cnt_q != '0);
	assign full      = (cnt_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/u8u16_back.sv =====
module u8u16_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  u8u16_pkg::u8u16_entry_t head,
	input  logic                    head_valid,
	output logic                    pop,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [15:0]             m_tdata,
	output logic                    m_tlast,
	output logic                    m_tuser
);

	logic [1:0]  idx_q;
	logic        valid_q;
	logic [15:0] unit_q;
	logic        run_end_q;
	logic        str_end_q;

	logic        load;
	logic        run_end;
	logic [15:0] unit_sel;

	always_comb begin
		unique case (idx_q)
			2'd0:    unit_sel = head.units[0];
			2'd1:    unit_sel = head.units[1];
			2'd2:    unit_sel = head.units[2];
			default: unit_sel = u8u16_pkg::REPL_UNIT;
		endcase
	end

	assign load    = head_valid && (!valid_q || m_tready);
	assign run_end = (idx_q == (head.cnt - 2'd1));
	assign pop     = load && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= run_end ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q    <= unit_sel;
			run_end_q <= run_end;
			str_end_q <= run_end && head.last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = unit_q;
	assign m_tlast  = str_end_q;
	assign m_tuser  = run_end_q;

endmodule
